/* sv/ubf_pkg.sv */
// ----------------------------------------------------------------------------
// ubf_pkg
// Shared types and constants for the UTF-8 invalid byte filter.
// ----------------------------------------------------------------------------
package ubf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] ASCII_END   = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD_END    = 8'hF5;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] E0_FOLLOW_MIN = 8'hA0;
  localparam logic [7:0] F0_FOLLOW_MIN = 8'h90;
  localparam logic [7:0] F4_FOLLOW_END = 8'h90;
  localparam logic [7:0] SURR_FOLLOW_MIN = 8'hA0;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  // One classified group: up to four kept bytes, count zero means marker only
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            last;
  } grp_t;

endpackage

/* sv/ubf_front.sv */
// ----------------------------------------------------------------------------
// ubf_front
// Accepts raw bytes, tracks the open sequence and forms groups of kept bytes.
// ----------------------------------------------------------------------------
module ubf_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        grp_valid,
  output ubf_pkg::grp_t grp
);
  import ubf_pkg::*;

  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] hcnt_r, hcnt_nxt;
  logic [2:0] slen_r, slen_nxt;
  logic       open_seq, fol, done, sur;

  always_comb begin
    open_seq = slen_r != 3'd0;
    fol = (in_byte[7:6] == CONT_TAG) &&
          !(hcnt_r == 2'd1 &&
            ((held_r[0] == LEAD_E0 && in_byte < E0_FOLLOW_MIN) ||
             (held_r[0] == LEAD_F0 && in_byte < F0_FOLLOW_MIN) ||
             (held_r[0] == LEAD_F4 && in_byte >= F4_FOLLOW_END)));
    done = ({1'b0, hcnt_r} + 3'd1) >= slen_r;
    sur  = held_r[0] == LEAD_ED && hcnt_r >= 2'd2 && held_r[1] >= SURR_FOLLOW_MIN;

    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    slen_nxt = slen_r;
    grp.cnt  = 3'd0;
    grp.last = in_last;
    grp.data[3] = in_byte;
    for (int i = 0; i < 3; i++) begin
      if (i == int'(hcnt_r)) begin
        grp.data[i] = in_byte;
      end else begin
        grp.data[i] = held_r[i];
      end
    end

    if (open_seq && fol) begin
      if (done) begin
        if (!sur) begin
          grp.cnt = {1'b0, hcnt_r} + 3'd1;
        end
        hcnt_nxt = 2'd0;
        slen_nxt = 3'd0;
      end else begin
        held_nxt[hcnt_r] = in_byte;
        hcnt_nxt = hcnt_r + 2'd1;
      end
    end else begin
      hcnt_nxt = 2'd0;
      slen_nxt = 3'd0;
      grp.data[0] = in_byte;
      if (in_byte < ASCII_END) begin
        grp.cnt = 3'd1;
      end else if (in_byte >= LEAD2_MIN && in_byte < LEAD_END) begin
        held_nxt[0] = in_byte;
        hcnt_nxt = 2'd1;
        if (in_byte < LEAD3_MIN) begin
          slen_nxt = 3'd2;
        end else if (in_byte < LEAD4_MIN) begin
          slen_nxt = 3'd3;
        end else begin
          slen_nxt = 3'd4;
        end
      end
    end

    if (in_last) begin
      hcnt_nxt = 2'd0;
      slen_nxt = 3'd0;
    end
    if (grp.cnt == 3'd0) begin
      grp.data = '0;
    end
    grp_valid = acc && (grp.cnt != 3'd0 || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= 2'd0;
      slen_r <= 3'd0;
    end else if (acc) begin
      hcnt_r <= hcnt_nxt;
      slen_r <= slen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
    end
  end

endmodule

/* sv/ubf_queue.sv */
// ----------------------------------------------------------------------------
// ubf_queue
// Short queue of classified groups between the front and back parts.
// ----------------------------------------------------------------------------
module ubf_queue #(
  parameter int unsigned DEPTH = ubf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ubf_pkg::grp_t wr_grp,
  input  logic          rd_en,
  output ubf_pkg::grp_t rd_grp,
  output logic          q_full,
  output logic          q_empty
);
  import ubf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  grp_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign q_full  = cnt_r == FULL_CNT;
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_grp  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_grp;
    end
  end

endmodule

/* sv/ubf_back.sv */
// ----------------------------------------------------------------------------
// ubf_back
// Serializes the head group into result words, one byte per pop.
// ----------------------------------------------------------------------------
module ubf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ubf_pkg::grp_t head,
  input  logic          head_valid,
  input  logic          pop,
  output logic          head_done,
  output logic [7:0]    out_byte,
  output logic          out_empty,
  output logic          out_last
);
  import ubf_pkg::*;

  logic [1:0] idx_r;
  logic       fin;

  assign fin       = head.cnt == 3'd0 || ({1'b0, idx_r} == head.cnt - 3'd1);
  assign head_done = pop && head_valid && fin;
  assign out_byte  = head.data[idx_r];
  assign out_empty = head.cnt == 3'd0;
  assign out_last  = head.last && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (pop && head_valid) begin
      idx_r <= fin ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

/* sv/utf8_invalid_byte_filter.sv */
// ----------------------------------------------------------------------------
// utf8_invalid_byte_filter
// Streaming UTF-8 validator: passes only well-formed UTF-8 bytes.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while full is low and delivers one result word per
// pop. A byte is classified in the cycle it is pushed; a complete character
// (1 to 4 bytes) enters the group queue and drains one byte per pop.
// Multi-byte characters are released only once their final byte arrives.
// Sustained rate is one byte per cycle while pop is held, set by the
// single-byte serializer; the QUEUE_DEPTH-entry group queue absorbs bursts.
module utf8_invalid_byte_filter #(
  parameter int unsigned QUEUE_DEPTH = ubf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_empty,
  output logic       out_last
);
  import ubf_pkg::*;

  grp_t fr_grp, hd_grp;
  logic fr_valid, hd_done, acc;

  assign acc = push && !full;

  ubf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .grp_valid (fr_valid),
    .grp       (fr_grp)
  );

  ubf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_valid),
    .wr_grp  (fr_grp),
    .rd_en   (hd_done),
    .rd_grp  (hd_grp),
    .q_full  (full),
    .q_empty (empty)
  );

  ubf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (hd_grp),
    .head_valid (!empty),
    .pop        (pop),
    .head_done  (hd_done),
    .out_byte   (out_byte),
    .out_empty  (out_empty),
    .out_last   (out_last)
  );

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_empty |-> out_last)
    else $error("marker word without last flag");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("queue full and empty at once");

  a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_last |=> !empty)
    else $error("end of stream left no result");

endmodule
